@@ rtl/core/lkv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int unsigned WORD_W = 32;

  // lookup pass: walks the chain once and collects the matching entry
  typedef struct packed {
    logic              active;
    logic              hit;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] data;
  } probe_t;

  // update pass: shifts entries one cell down until the request settles
  typedef struct packed {
    logic              active;
    logic              done;
    logic              evict;
    logic [WORD_W-1:0] req_key;
    logic [WORD_W-1:0] carry_key;
    logic [WORD_W-1:0] carry_data;
    logic [WORD_W-1:0] ev_key;
  } token_t;

endpackage

`default_nettype wire

@@ rtl/core/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with LRU replacement, built as a chain of
// DEPTH cells kept in recency order (cell 0 is the most recent entry). Each
// request makes two passes down the chain, one cell per cycle: a lookup pass
// that finds the key, then an update pass that moves the entry to the front,
// shifting the more recent ones down a cell and dropping the least recent one
// when the cache is full. A get that misses skips the update pass. Requests
// are handled one at a time, and a finished result may wait in the output
// register while the next request is taken.
// Writing capacity empties the cache at once; values above DEPTH act as
// DEPTH and zero acts as one.
module lru_key_value_cache #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [31:0] read_value,
  output logic               evicted,
  output logic signed [31:0] evicted_key,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         capacity
);
  import lkv_pkg::*;

  localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t            state;
  logic [4:0]        cap_setting;
  logic              req_put;
  logic [WORD_W-1:0] req_key;
  logic [WORD_W-1:0] req_value;
  logic              res_hit;
  logic [WORD_W-1:0] res_data;
  logic              res_evict;
  logic [WORD_W-1:0] res_evk;

  probe_t probe_head;
  token_t tok_head;
  probe_t probe_link [DEPTH+1];
  token_t tok_link   [DEPTH+1];
  logic [DEPTH-1:0] probe_act;

  logic              clear;
  logic [WORD_W-1:0] masked_key;
  logic [8:0]        cap_ext;
  logic [8:0]        last_full;
  logic [IW-1:0]     last_pos;

  assign cfg_ready  = (state == ST_IDLE);
  assign clear      = cfg_valid && cfg_ready;
  assign in_ready   = (state == ST_IDLE) && !cfg_valid;
  assign masked_key = WORD_W'(key[KW-1:0]);

  assign cap_ext = 9'(cap_setting);
  always_comb begin
    if (cap_ext == 9'd0) begin
      last_full = 9'd0;
    end else if (cap_ext > 9'(DEPTH)) begin
      last_full = 9'(DEPTH - 1);
    end else begin
      last_full = cap_ext - 9'd1;
    end
  end
  assign last_pos = last_full[IW-1:0];

  assign probe_link[0] = probe_head;
  assign tok_link[0]   = tok_head;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lkv_cell #(
      .KW    (KW),
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear),
      .last_pos  (last_pos),
      .probe_in  (probe_link[i]),
      .probe_out (probe_link[i+1]),
      .tok_in    (tok_link[i]),
      .tok_out   (tok_link[i+1])
    );
    assign probe_act[i] = probe_link[i+1].active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cap_setting <= 5'd16;
      out_valid   <= 1'b0;
      probe_head  <= '0;
      tok_head    <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      if (clear) begin
        cap_setting <= capacity;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_put    <= command;
            req_key    <= masked_key;
            req_value  <= value;
            probe_head <= '{active: 1'b1, hit: 1'b0, key: masked_key, data: '0};
            state      <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          probe_head.active <= 1'b0;
          if (probe_link[DEPTH].active) begin
            res_hit   <= probe_link[DEPTH].hit;
            res_data  <= probe_link[DEPTH].data;
            res_evict <= 1'b0;
            res_evk   <= '0;
            if (!req_put && !probe_link[DEPTH].hit) begin
              // a get that misses leaves the cache as it is
              state <= ST_DONE;
            end else begin
              tok_head <= '{active: 1'b1, done: 1'b0, evict: 1'b0,
                            req_key: req_key, carry_key: req_key,
                            carry_data: req_put ? req_value : probe_link[DEPTH].data,
                            ev_key: '0};
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          tok_head.active <= 1'b0;
          if (tok_link[DEPTH].active) begin
            res_evict <= tok_link[DEPTH].evict;
            res_evk   <= tok_link[DEPTH].ev_key;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            hit         <= res_hit;
            read_value  <= (!req_put && res_hit) ? res_data : '0;
            evicted     <= res_evict;
            evicted_key <= res_evict ? res_evk : '0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // every update pass settles somewhere in the chain
  a_walk_settles: assert property (@(posedge clk) disable iff (rst)
    tok_link[DEPTH].active |-> tok_link[DEPTH].done)
    else $error("update pass left the chain unsettled");

  a_one_probe: assert property (@(posedge clk) disable iff (rst)
    $onehot0(probe_act))
    else $error("more than one lookup in flight");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(evicted && hit))
    else $error("eviction reported on a hit");

  a_value_on_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_value != 32'sd0) |-> hit)
    else $error("read value without a hit");

  a_walk_after_probe: assert property (@(posedge clk) disable iff (rst)
    tok_link[0].active |-> $past(state == ST_PROBE && probe_link[DEPTH].active))
    else $error("update pass launched without a finished lookup");

endmodule

`default_nettype wire

@@ rtl/core/lkv_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell #(
  parameter int KW    = 32,
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic [IW-1:0]   last_pos,
  input  lkv_pkg::probe_t probe_in,
  output lkv_pkg::probe_t probe_out,
  input  lkv_pkg::token_t tok_in,
  output lkv_pkg::token_t tok_out
);
  import lkv_pkg::*;

  logic              valid;
  logic [KW-1:0]     entry_key;
  logic [WORD_W-1:0] entry_data;

  logic   probe_match;
  logic   tok_take;
  logic   tok_match;
  logic   is_last;
  probe_t probe_next;
  token_t tok_next;

  assign probe_match = valid && (entry_key == probe_in.key[KW-1:0]);
  assign tok_take    = tok_in.active && !tok_in.done;
  assign tok_match   = valid && (entry_key == tok_in.req_key[KW-1:0]);
  assign is_last     = (last_pos == IW'(INDEX));

  always_comb begin
    probe_next = probe_in;
    if (probe_in.active && probe_match) begin
      probe_next.hit  = 1'b1;
      probe_next.data = entry_data;
    end
  end

  // The cell always takes the carried entry; only what moves on differs.
  always_comb begin
    tok_next = tok_in;
    if (tok_take) begin
      if (!valid || tok_match) begin
        tok_next.done = 1'b1;
      end else if (is_last) begin
        // drop the least recent entry off the end of the used region
        tok_next.done   = 1'b1;
        tok_next.evict  = 1'b1;
        tok_next.ev_key = WORD_W'(entry_key);
      end else begin
        tok_next.carry_key  = WORD_W'(entry_key);
        tok_next.carry_data = entry_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      probe_out <= '0;
      tok_out   <= '0;
    end else begin
      probe_out <= probe_next;
      tok_out   <= tok_next;
      if (clear) begin
        valid <= 1'b0;
      end else if (tok_take) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take) begin
      entry_key  <= tok_in.carry_key[KW-1:0];
      entry_data <= tok_in.carry_data;
    end
  end

endmodule

`default_nettype wire

@@ test/lru_key_value_cache_test.sv @@
`timescale 1ns / 1ps

module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] read_value;
    logic              evicted;
    logic [WORD_W-1:0] evicted_key;
  } cache_reply_t;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic                     command     = CMD_GET;
  logic signed [WORD_W-1:0] key         = '0;
  logic signed [WORD_W-1:0] value       = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic                     hit;
  logic signed [WORD_W-1:0] read_value;
  logic                     evicted;
  logic signed [WORD_W-1:0] evicted_key;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  logic [4:0]               capacity    = 5'd16;

  lru_key_value_cache #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted),
    .evicted_key(evicted_key),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the cache contents
  logic              cache_valid [DEPTH];
  logic [WORD_W-1:0] cache_key   [DEPTH];
  logic [WORD_W-1:0] cache_data  [DEPTH];
  int                cache_rank  [DEPTH];
  int                cache_fill;
  int                cache_limit;

  cache_req_t   requests_to_send[$];
  cache_reply_t replies_due[$];
  logic [WORD_W-1:0] key_pool[$];

  logic [4:0] phase_caps [10] = '{5'd31, 5'd1, 5'd17, 5'd3, 5'd16,
                                  5'd8, 5'd0, 5'd5, 5'd2, 5'd12};

  int  mismatches   = 0;
  int  results_seen = 0;
  bit  req_taken    = 1'b0;
  int  burst_left   = 0;
  int  gap_left     = 0;
  int  hold_left    = 0;
  int  seg_left     = 0;
  int  seg_mode     = 0;

  function automatic void set_capacity(input logic [4:0] cap);
    if (cap == 0)
      cache_limit = 1;
    else if (cap > DEPTH)
      cache_limit = DEPTH;
    else
      cache_limit = cap;
    for (int i = 0; i < DEPTH; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i]   = '0;
      cache_data[i]  = '0;
      cache_rank[i]  = 0;
    end
    cache_fill = 0;
  endfunction

  function automatic cache_reply_t predict_cache_access(input cache_req_t req);
    cache_reply_t res;
    int found;
    int slot;
    int r;
    res   = '0;
    found = -1;
    slot  = -1;
    for (int i = 0; i < DEPTH; i++)
      if (found < 0 && cache_valid[i] && cache_key[i] == req.key)
        found = i;
    if (found >= 0) begin
      res.hit = 1'b1;
      if (req.command == CMD_PUT)
        cache_data[found] = req.value;
      else
        res.read_value = cache_data[found];
      // promote to most recent; entries ahead of it age by one
      r = cache_rank[found];
      for (int i = 0; i < DEPTH; i++)
        if (cache_valid[i] && cache_rank[i] < r)
          cache_rank[i]++;
      cache_rank[found] = 0;
    end else if (req.command == CMD_PUT) begin
      if (cache_fill >= cache_limit) begin
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && cache_valid[i] && cache_rank[i] == cache_fill - 1)
            slot = i;
        if (slot >= 0) begin
          res.evicted     = 1'b1;
          res.evicted_key = cache_key[slot];
          cache_valid[slot] = 1'b0;
          cache_fill--;
        end
      end
      if (slot < 0)
        for (int i = 0; i < DEPTH; i++)
          if (slot < 0 && !cache_valid[i])
            slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < DEPTH; i++)
          if (cache_valid[i])
            cache_rank[i]++;
        cache_valid[slot] = 1'b1;
        cache_key[slot]   = req.key;
        cache_data[slot]  = req.value;
        cache_rank[slot]  = 0;
        cache_fill++;
      end
    end
    return res;
  endfunction

  function automatic void queue_req(input logic cmd, input logic [WORD_W-1:0] k,
                                    input logic [WORD_W-1:0] v);
    cache_req_t req;
    req.command = cmd;
    req.key     = k;
    req.value   = v;
    requests_to_send.insert(requests_to_send.size(), req);
  endfunction

  // mostly keys from a pool a little larger than the capacity, so gets hit
  // and puts both update and evict
  function automatic void queue_random_phase(input int count, input logic [4:0] cap);
    int eff;
    int pool_size;
    logic [WORD_W-1:0] k;
    eff       = (cap == 0) ? 1 : ((cap > DEPTH) ? DEPTH : cap);
    pool_size = eff + $urandom_range(1, 4);
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) begin
      k = $urandom;
      key_pool.insert(key_pool.size(), k);
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0)
        k = $urandom;
      else
        k = key_pool[$urandom_range(0, pool_size - 1)];
      queue_req(($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET, k, $urandom);
    end
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (requests_to_send.size() != 0 || in_valid || replies_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    capacity  <= cap;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready))
      @(posedge clk);
    set_capacity(cap);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin : drive_requests
    cache_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_to_send.size() != 0) begin
        nxt = requests_to_send.pop_front();
        in_valid <= 1'b1;
        command  <= nxt.command;
        key      <= nxt.key;
        value    <= nxt.value;
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : track_requests
    cache_reply_t due;
    if (!rst && in_valid && in_ready) begin
      due = predict_cache_access(cache_req_t'({command, key, value}));
      replies_due.insert(replies_due.size(), due);
      req_taken = 1'b1;
    end
  end

  // reply side: segments of steady, random and sparse readiness, plus one long hold
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 150);
        seg_mode = $urandom_range(0, 2);
      end
      seg_left--;
      case (seg_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= (seg_left % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_replies
    cache_reply_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (results_seen == 120)
        hold_left = 400;
      if (replies_due.size() == 0) begin
        $error("reply with no request outstanding");
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          mismatches++;
        end
        if (read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, read_value);
          mismatches++;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, evicted);
          mismatches++;
        end
        if (evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, evicted_key);
          mismatches++;
        end
      end
    end
  end

  initial begin
    set_capacity(5'd16);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full capacity: key and value extremes, get miss, put update, get hits
    queue_req(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(CMD_PUT, 32'h0000_0000, 32'h0000_3039);
    queue_req(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678);
    queue_req(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_idle();

    // zero capacity behaves as one entry
    write_capacity(5'd0);
    queue_req(CMD_PUT, 32'd5, 32'd1);
    queue_req(CMD_PUT, 32'd6, 32'd2);
    queue_req(CMD_GET, 32'd5, 32'd0);
    queue_req(CMD_GET, 32'd6, 32'd0);
    queue_req(CMD_PUT, 32'd6, 32'd3);
    wait_idle();

    // two entries: a get refreshes recency so the other one is evicted
    write_capacity(5'd2);
    queue_req(CMD_PUT, 32'd1, 32'd10);
    queue_req(CMD_PUT, 32'd2, 32'd20);
    queue_req(CMD_GET, 32'd1, 32'd0);
    queue_req(CMD_PUT, 32'd3, 32'd30);
    queue_req(CMD_GET, 32'd2, 32'd0);
    wait_idle();

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      queue_random_phase(90, phase_caps[p]);
      wait_idle();
    end

    repeat (2 * DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
